>>> rtl/rsel_pkg.sv
package rsel_pkg;

  localparam int unsigned LEAVES  = 16;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned LEVELS  = 4;
  localparam int unsigned POS_W   = KEY_W + 1;

  localparam logic [1:0] REQ_LOAD        = 2'd0;
  localparam logic [1:0] REQ_REPLACE_TOP = 2'd1;
  localparam logic [1:0] REQ_REPLACE_IDX = 2'd2;
  localparam logic [1:0] REQ_NEW_RUN     = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [KEY_W-1:0]        leaf_index;
    logic signed [VAL_W-1:0] new_value;
    logic                    valid_flag;
  } rsel_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic [KEY_W-1:0]        top_key;
    logic                    top_valid;
    logic [CNT_W-1:0]        invalid_count;
    logic                    run_exhausted;
  } rsel_out_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    valid;
    logic [KEY_W-1:0]        key;
  } rsel_entry_t;

endpackage

>>> rtl/replacement_selection_tree.sv
// Tournament tree for replacement-selection run generation, 16 leaves.
// Input channel: an item (in_item) is taken at a rising edge where start is
// high and busy is low. Result channel: out_item is valid for exactly one
// cycle while out_strobe is high; the receiver cannot stall it, so it must
// sample the result in that cycle. One result follows every item.
// Load and replace requests write the leaf at the accept edge and then replay
// one tree level per cycle through a single shared compare unit over the four
// levels, the last of which also writes the top entry. The strobe is high in
// the cycle after that, and busy drops in that strobe cycle, so a new item
// is taken only after the replay of the previous one has finished.
// A new-run request only sets every valid bit and clears the invalid count;
// its result is strobed in the next cycle and busy stays low.
// After reset the top entry and the invalid count are zero and the block is
// idle; leaves must all be loaded before their contents mean anything.
module replacement_selection_tree
  import rsel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rsel_in_t  in_item,
  output logic      out_strobe,
  output rsel_out_t out_item
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CLIMB = 1'b1;

  logic                    state_r, state_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  rsel_entry_t             carry_r, carry_nxt;
  rsel_entry_t             top_r, top_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    strobe_r, strobe_nxt;

  logic signed [VAL_W-1:0] leaf_val_r [LEAVES];
  logic [LEAVES-1:0]       leaf_vld_r;
  logic signed [VAL_W-1:0] node_val_r [LEAVES];
  logic [KEY_W-1:0]        node_key_r [LEAVES];
  logic [LEAVES-1:0]       node_vld_r;

  logic                    accept;
  logic                    is_update;
  logic [KEY_W-1:0]        tgt_idx;
  logic                    tgt_vld;
  logic [POS_W-1:0]        sib_pos;
  logic [KEY_W-1:0]        sib_addr;
  logic [KEY_W-1:0]        parent;
  rsel_entry_t             sib;
  rsel_entry_t             left_e, right_e, win;

  assign accept    = start && (state_r == ST_IDLE);
  assign is_update = (in_item.req_type != REQ_NEW_RUN);

  // Target leaf and its run flag for the three update requests.
  always_comb begin
    tgt_idx = in_item.leaf_index;
    tgt_vld = 1'b1;
    unique case (in_item.req_type)
      REQ_LOAD: begin
        tgt_vld = 1'b1;
      end
      REQ_REPLACE_TOP: begin
        tgt_idx = top_r.key;
        tgt_vld = in_item.valid_flag;
      end
      REQ_REPLACE_IDX: begin
        tgt_vld = !(in_item.new_value < top_r.value);
      end
      default: begin
        tgt_vld = 1'b1;
      end
    endcase
  end

  // Shared compare unit: the carried winner meets its sibling at one level.
  assign sib_pos  = pos_r ^ POS_W'(1);
  assign sib_addr = sib_pos[KEY_W-1:0];
  assign parent   = pos_r[POS_W-1:1];

  always_comb begin
    if (sib_pos[POS_W-1]) begin
      sib.value = leaf_val_r[sib_addr];
      sib.valid = leaf_vld_r[sib_addr];
      sib.key   = sib_addr;
    end else begin
      sib.value = node_val_r[sib_addr];
      sib.valid = node_vld_r[sib_addr];
      sib.key   = node_key_r[sib_addr];
    end
    if (pos_r[0]) begin
      left_e  = sib;
      right_e = carry_r;
    end else begin
      left_e  = carry_r;
      right_e = sib;
    end
    if (left_e.valid != right_e.valid) begin
      win = left_e.valid ? left_e : right_e;
    end else begin
      win = (right_e.value < left_e.value) ? right_e : left_e;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    carry_nxt  = carry_r;
    top_nxt    = top_r;
    cnt_nxt    = cnt_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_update) begin
            state_nxt       = ST_CLIMB;
            pos_nxt         = {1'b1, tgt_idx};
            carry_nxt.value = in_item.new_value;
            carry_nxt.valid = tgt_vld;
            carry_nxt.key   = tgt_idx;
            if (!tgt_vld && (cnt_r != CNT_W'(LEAVES))) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            top_nxt.valid = 1'b1;
            cnt_nxt       = '0;
            strobe_nxt    = 1'b1;
          end
        end
      end
      ST_CLIMB: begin
        carry_nxt = win;
        pos_nxt   = {1'b0, parent};
        if (parent == KEY_W'(1)) begin
          top_nxt    = win;
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      top_r    <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      top_r    <= top_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    carry_r <= carry_nxt;
  end

  // Leaf and node storage; a new run sets every valid bit at once.
  always_ff @(posedge clk) begin
    if (accept && is_update) begin
      leaf_val_r[tgt_idx] <= in_item.new_value;
      leaf_vld_r[tgt_idx] <= tgt_vld;
    end else if (accept) begin
      leaf_vld_r <= '1;
    end
    if (state_r == ST_CLIMB) begin
      node_val_r[parent] <= win.value;
      node_key_r[parent] <= win.key;
      node_vld_r[parent] <= win.valid;
    end else if (accept && !is_update) begin
      node_vld_r <= '1;
    end
  end

  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = strobe_r;
  assign out_item.top_value     = top_r.value;
  assign out_item.top_key       = top_r.key;
  assign out_item.top_valid     = top_r.valid;
  assign out_item.invalid_count = cnt_r;
  assign out_item.run_exhausted = (cnt_r == CNT_W'(LEAVES));

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LEAVES))
    else $error("invalid count above leaf count");

  a_climb_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLIMB) |-> (pos_r >= POS_W'(2)))
    else $error("replay walked past the root");

  a_new_run_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.req_type == REQ_NEW_RUN)) |=> out_strobe)
    else $error("new-run result not strobed in the next cycle");

  a_update_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.req_type != REQ_NEW_RUN))
      |-> ##(LEVELS + 1) (out_strobe && !busy))
    else $error("update result not strobed after the tree replay");
`endif

endmodule
